// File: rtl/iiel_pkg.sv
// Package for the indexed insert/erase list.
// Holds the request and status codes, field widths and the cell control type.
// No dependencies.
package iiel_pkg;

    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 5;
    localparam int VALUE_W  = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Broadcast from the control logic to every cell in the row.
    typedef struct packed {
        logic ins;
        logic ers;
    } t_cell_ctl;

endpackage

// File: rtl/indexed_insert_erase_list.sv
// Indexed insert/erase list: an ordered list of up to CAPACITY bytes held in a
// row of cells. Each beat reads, inserts or erases at an index and yields one
// result beat with the byte read, a status and the new count. One request is
// taken every cycle unless stalled; each result sits in an output register while
// the next request is taken. The request path is a position compare in every
// cell in parallel plus an OR across the row for the read data. The store
// holds nothing meaningful after reset; the count is zero.
module indexed_insert_erase_list
    import iiel_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [VALUE_W-1:0]  o_read_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_read;
    logic [STATUS_W-1:0] r_out_status;
    logic [COUNT_W-1:0] r_out_count;

    logic               accept;
    logic               do_ins;
    logic               do_ers;
    logic [CW-1:0]      idx_ext;
    logic [CW-1:0]      cnt_ext;
    logic [CW-1:0]      cnt_next_ext;
    logic [VALUE_W-1:0] rd_or;
    logic [VALUE_W-1:0] rd_val;
    logic [STATUS_W-1:0] st_val;
    t_cell_ctl          ctl;

    logic [VALUE_W-1:0] cell_q   [CAPACITY];
    logic [VALUE_W-1:0] cell_tap [CAPACITY];

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign idx_ext = CW'(i_index);
    assign cnt_ext = CW'(r_count);

    always_comb begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_or = rd_or | cell_tap[k];
        end
    end

    always_comb begin
        do_ins = 1'b0;
        do_ers = 1'b0;
        rd_val = '0;
        st_val = ST_OK;
        case (i_mode)
            MODE_READ: begin
                if (idx_ext < cnt_ext) begin
                    rd_val = rd_or;
                end else begin
                    st_val = ST_RANGE;
                end
            end
            MODE_INSERT: begin
                if (idx_ext > cnt_ext) begin
                    st_val = ST_RANGE;
                end else if (cnt_ext >= CAP_V) begin
                    st_val = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            MODE_ERASE: begin
                if (idx_ext >= cnt_ext) begin
                    st_val = ST_RANGE;
                end else begin
                    do_ers = 1'b1;
                end
            end
            default: begin
                // Unused mode: no change, answers ok with the current count.
                st_val = ST_OK;
            end
        endcase
    end

    assign ctl.ins = accept && do_ins;
    assign ctl.ers = accept && do_ers;

    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.ers) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign cnt_next_ext = CW'(n_count);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [VALUE_W-1:0] lower;
            logic [VALUE_W-1:0] upper;
            if (g == 0) begin : g_first
                assign lower = cell_q[g];
            end else begin : g_mid_lo
                assign lower = cell_q[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign upper = cell_q[g];
            end else begin : g_mid_hi
                assign upper = cell_q[g+1];
            end
            iiel_cell #(
                .POS (g),
                .CW  (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_index (idx_ext),
                .i_value (i_value),
                .i_lower (lower),
                .i_upper (upper),
                .o_data  (cell_q[g]),
                .o_tap   (cell_tap[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_read   <= rd_val;
            r_out_status <= st_val;
            r_out_count  <= cnt_next_ext[COUNT_W-1:0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_out_read;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;

    // The count never exceeds the capacity of the row.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_ext <= CAP_V)
        else $error("element count exceeds capacity");

    // A pending result always reports the count left by the latest request.
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count == cnt_ext[COUNT_W-1:0]))
        else $error("reported count differs from stored count");

    // A successful insert grows the list by exactly one element.
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ins |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list");

    // A full status is only given when the list is at capacity.
    a_full_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (cnt_ext == CAP_V))
        else $error("full status with spare capacity");

    // Insert and erase never act in the same cycle.
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.ins && ctl.ers))
        else $error("insert and erase together");

endmodule

// File: rtl/iiel_cell.sv
// One storage cell of the indexed insert/erase list.
// Holds one element; on an insert or erase takes a neighbour's or the new element.
// Depends on iiel_pkg.
module iiel_cell
    import iiel_pkg::*;
#(
    parameter int POS = 0,
    parameter int CW  = 5
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [CW-1:0]      i_index,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [VALUE_W-1:0] i_lower,
    input  logic [VALUE_W-1:0] i_upper,
    output logic [VALUE_W-1:0] o_data,
    output logic [VALUE_W-1:0] o_tap
);

    localparam logic [CW-1:0] POS_V = CW'(POS);

    logic [VALUE_W-1:0] r_data;
    logic [VALUE_W-1:0] n_data;
    logic               hit;
    logic               above;

    assign hit   = (POS_V == i_index);
    assign above = (POS_V > i_index);

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins && above) begin
            n_data = i_lower;
        end else if (i_ctl.ins && hit) begin
            n_data = i_value;
        end else if (i_ctl.ers && (above || hit)) begin
            n_data = i_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = hit ? r_data : '0;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the indexed insert/erase list.
// Drives read, insert and erase beats under random idling and back-pressure and
// checks every result beat against an in-bench list model; needs only iiel_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import iiel_pkg::*;

    localparam int CAPACITY = 16;
    localparam int unsigned RUN_LIMIT = 500000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS = 10;
    // The fourth request code has no meaning; the block must answer it and change nothing.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_list_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [MODE_W-1:0]   i_mode = MODE_READ;
    logic [INDEX_W-1:0]  i_index = '0;
    logic [VALUE_W-1:0]  i_value = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [VALUE_W-1:0]  o_read_value;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_count;

    // Model of the list contents, advanced as each request beat is accepted.
    logic [VALUE_W-1:0] shadow_bytes [CAPACITY];
    int unsigned        shadow_len = 0;
    int unsigned        peak_len = 0;
    t_list_result       expected_results [$];
    t_list_result       oldest;

    int unsigned requests_sent = 0;
    int unsigned results_checked = 0;
    int unsigned failures = 0;
    int unsigned status_seen [3] = '{0, 0, 0};
    int unsigned cycle_count = 0;

    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_ack = 1'b0;
    int unsigned hold_left = 0;
    int unsigned rx_run = 0;

    indexed_insert_erase_list #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly short idle runs, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic t_list_result predict_list_op(input logic [MODE_W-1:0] mode,
                                                     input logic [INDEX_W-1:0] idx,
                                                     input logic [VALUE_W-1:0] val);
        t_list_result res;
        int unsigned  pos;
        res = '0;
        pos = 32'(idx);
        case (mode)
            MODE_READ: begin
                if (pos < shadow_len)
                    res.read_value = shadow_bytes[pos];
                else
                    res.status = ST_RANGE;
            end
            MODE_INSERT: begin
                // The position is checked before the fill level.
                if (pos > shadow_len) begin
                    res.status = ST_RANGE;
                end else if (shadow_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int j = shadow_len; j > pos; j--)
                        shadow_bytes[j] = shadow_bytes[j-1];
                    shadow_bytes[pos] = val;
                    shadow_len++;
                end
            end
            MODE_ERASE: begin
                if (pos >= shadow_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int j = pos + 1; j < shadow_len; j++)
                        shadow_bytes[j-1] = shadow_bytes[j];
                    shadow_len--;
                end
            end
            default: ;
        endcase
        res.count = COUNT_W'(shadow_len);
        return res;
    endfunction

    // Offers one request beat, holds it until accepted, then records what it should produce.
    task automatic send_req(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] idx,
                            input logic [VALUE_W-1:0] val);
        int unsigned  gap;
        t_list_result res;
        gap = (tx_quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_index <= idx;
        i_value <= val;
        do @(posedge i_clk); while (o_stall);
        res = predict_list_op(mode, idx, val);
        expected_results.push_back(res);
        requests_sent++;
        status_seen[res.status]++;
        if (shadow_len > peak_len)
            peak_len = shadow_len;
    endtask

    // Mostly requests that address a live position; grow tilts the mix towards inserts.
    task automatic random_req(input bit grow);
        int unsigned        r;
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] idx;
        r = $urandom_range(0, 99);
        if (r < 3)
            mode = MODE_UNUSED;
        else if (r < (grow ? 55 : 25))
            mode = MODE_INSERT;
        else if (r < 75)
            mode = MODE_ERASE;
        else
            mode = MODE_READ;
        r = $urandom_range(0, 99);
        if (r < 8)
            idx = INDEX_W'($urandom);
        else if (mode == MODE_INSERT)
            idx = INDEX_W'($urandom_range(0, shadow_len));
        else if (shadow_len == 0)
            idx = '0;
        else
            idx = INDEX_W'($urandom_range(0, shadow_len - 1));
        send_req(mode, idx, VALUE_W'($urandom));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_failure(input string what);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("Mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                note_failure($sformatf(
                    "unexpected result beat: value %0d status %0d count %0d",
                    o_read_value, o_status, o_count));
            end else begin
                oldest = expected_results.pop_front();
                results_checked++;
                if (o_read_value !== oldest.read_value || o_status !== oldest.status ||
                    o_count !== oldest.count)
                    note_failure($sformatf(
                        "expected value %0d status %0d count %0d, got %0d %0d %0d",
                        oldest.read_value, oldest.status, oldest.count,
                        o_read_value, o_status, o_count));
            end
        end
    end

    // Result-side back-pressure; a toggle of hold_req asks for one long hold-off.
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (rx_run != 0) begin
            rx_run  <= rx_run - 1;
            i_stall <= 1'b1;
        end else if (rx_quiet || $urandom_range(0, 99) < 60) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= 1'b1;
            rx_run  <= idle_len() - 1;
        end
    end

    task automatic test_empty_list();
        send_req(MODE_READ, 5'd0, 8'h00);
        send_req(MODE_ERASE, 5'd0, 8'h00);
        send_req(MODE_INSERT, 5'd1, 8'h11);
        send_req(MODE_UNUSED, 5'd31, 8'hFF);
    endtask

    task automatic test_full_list();
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] val;
        // Fill at the front, the back and the middle in turn.
        for (int i = 0; i < CAPACITY; i++) begin
            case (i % 3)
                0:       idx = '0;
                1:       idx = INDEX_W'(shadow_len);
                default: idx = INDEX_W'(shadow_len / 2);
            endcase
            case (i)
                0:       val = 8'h00;
                1:       val = 8'hFF;
                2:       val = 8'hA5;
                3:       val = 8'h5A;
                default: val = VALUE_W'($urandom);
            endcase
            send_req(MODE_INSERT, idx, val);
        end
        send_req(MODE_INSERT, 5'd3, 8'h77);
        send_req(MODE_INSERT, 5'd17, 8'h77);
        send_req(MODE_READ, 5'd15, 8'h00);
        send_req(MODE_READ, 5'd16, 8'h00);
        send_req(MODE_ERASE, 5'd16, 8'h00);
        send_req(MODE_ERASE, 5'd15, 8'h00);
        send_req(MODE_ERASE, 5'd0, 8'h00);
        send_req(MODE_ERASE, 5'd6, 8'h00);
    endtask

    task automatic test_random_traffic();
        // Alternate between growing and shrinking so the fill level sweeps empty to full.
        for (int i = 0; i < 800; i++)
            random_req(((i / 60) % 2) == 0);
        drain_results();
    endtask

    task automatic test_quiet_stretch();
        tx_quiet = 1'b1;
        rx_quiet <= 1'b1;
        for (int i = 0; i < 120; i++)
            random_req(i < 60);
        tx_quiet = 1'b0;
        rx_quiet <= 1'b0;
    endtask

    task automatic test_backpressure();
        hold_req <= ~hold_req;
        for (int i = 0; i < 100; i++)
            random_req(i < 50);
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (shadow_bytes[k])
            shadow_bytes[k] = '0;
        shadow_len = 0;

        test_empty_list();
        test_full_list();
        test_random_traffic();
        test_quiet_stretch();
        test_backpressure();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results in %0d cycles, peak list length %0d",
                 requests_sent, results_checked, cycle_count, peak_len);
        $display("Outcomes: %0d ok, %0d out of range, %0d refused as full; %0d mismatches",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL], failures);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
